// ===== sv/pob_pkg.sv =====
package pob_pkg;

   localparam int CHANNELS_DEFAULT = 32;
   localparam int CHANNEL_W = 5;
   localparam int LENGTH_W = 16;
   localparam int PIN_W = 32;

   typedef enum logic [2:0] {
      OP_SET     = 3'd0,
      OP_TOGGLE  = 3'd1,
      OP_PULSE   = 3'd2,
      OP_ALL_OFF = 3'd3,
      OP_TICK    = 3'd4,
      OP_REFRESH = 3'd5,
      OP_READ    = 3'd6
   } op_type;

   typedef struct packed {
      op_type               operation;
      logic [CHANNEL_W-1:0] channel;
      logic                 level;
      logic [LENGTH_W-1:0]  pulse_length;
   } req_type;

   typedef struct packed {
      logic [PIN_W-1:0] pin_levels;
      logic             read_level;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      op_type              operation;
      logic                level;
      logic                length_nonzero;
      logic [LENGTH_W-1:0] pulse_length;
   } lane_cmd_type;

endpackage

// ===== sv/pob_lane.sv =====
module pob_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  pob_pkg::lane_cmd_type cmd,
   input  logic                  hit,
   output logic                  level_in,
   output logic                  level_ff
);

   logic [pob_pkg::LENGTH_W-1:0] counter_ff;
   logic [pob_pkg::LENGTH_W-1:0] counter_in;
   logic                         flag_ff;
   logic                         flag_in;
   logic                         counter_idle;

   assign counter_idle = (counter_ff == '0);

   always_comb begin
      level_in   = level_ff;
      counter_in = counter_ff;
      flag_in    = flag_ff;
      if (cmd.valid) begin
         unique case (cmd.operation)
            pob_pkg::OP_SET: begin
               if (hit) begin
                  level_in   = cmd.level;
                  counter_in = '0;
                  flag_in    = 1'b0;
               end
            end
            pob_pkg::OP_TOGGLE: begin
               if (hit) begin
                  level_in   = ~level_ff;
                  counter_in = '0;
                  flag_in    = 1'b0;
               end
            end
            pob_pkg::OP_PULSE: begin
               if (hit && cmd.length_nonzero) begin
                  level_in   = level_ff ^ counter_idle;
                  counter_in = cmd.pulse_length;
                  flag_in    = 1'b0;
               end
            end
            pob_pkg::OP_ALL_OFF: begin
               level_in   = 1'b0;
               counter_in = '0;
               flag_in    = 1'b0;
            end
            pob_pkg::OP_TICK: begin
               if (!counter_idle) begin
                  counter_in = counter_ff - 1'b1;
                  if (counter_ff == pob_pkg::LENGTH_W'(1)) begin
                     flag_in = 1'b1;
                  end
               end
            end
            pob_pkg::OP_REFRESH: begin
               if (flag_ff) begin
                  flag_in  = 1'b0;
                  level_in = ~level_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= 1'b0;
         counter_ff <= '0;
         flag_ff    <= 1'b0;
      end else begin
         level_ff   <= level_in;
         counter_ff <= counter_in;
         flag_ff    <= flag_in;
      end
   end

`ifndef SYNTHESIS
   a_flag_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      flag_ff |-> counter_idle)
      else $error("Expiry flag is set while the pulse counter is running.");

   a_all_off_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.valid && cmd.operation == pob_pkg::OP_ALL_OFF |=>
         !level_ff && !flag_ff && counter_ff == '0)
      else $error("All-off left state behind in a lane.");
`endif

endmodule

// ===== sv/pulse_output_bank.sv =====
// Channel   Ports                          Handshake
// input     start, busy, req_payload       accepted when start is high and busy is low
// result    rsp_strobe, rsp_payload        valid for one cycle while rsp_strobe is high
//
// Every item passes from acceptance into the input register, then through the
// lane update into the result register.
// A new item is accepted in every cycle; busy is always low.
// Synchronous reset clears every level, counter and flag and drops the strobe.
// The receiver cannot stall, so results are never held back.
module pulse_output_bank #(
   parameter int CHANNELS = pob_pkg::CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pob_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output pob_pkg::rsp_type rsp_payload
);

   logic                  cmd_valid_ff;
   pob_pkg::req_type      cmd_ff;
   pob_pkg::lane_cmd_type lane_cmd;
   logic [CHANNELS-1:0]   hit_vec;
   logic [CHANNELS-1:0]   level_next;
   logic [CHANNELS-1:0]   level_now;
   logic [pob_pkg::PIN_W-1:0] pins_in;
   logic                  read_in;
   logic                  rsp_strobe_ff;
   pob_pkg::rsp_type      rsp_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         cmd_ff <= req_payload;
      end
   end

   always_comb begin
      lane_cmd.valid          = cmd_valid_ff;
      lane_cmd.operation      = cmd_ff.operation;
      lane_cmd.level          = cmd_ff.level;
      lane_cmd.length_nonzero = (cmd_ff.pulse_length != '0);
      lane_cmd.pulse_length   = cmd_ff.pulse_length;
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      assign hit_vec[i] = (cmd_ff.channel == pob_pkg::CHANNEL_W'(i));

      pob_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .cmd      (lane_cmd),
         .hit      (hit_vec[i]),
         .level_in (level_next[i]),
         .level_ff (level_now[i])
      );
   end

   always_comb begin
      pins_in = '0;
      pins_in[CHANNELS-1:0] = level_next;
      read_in = (cmd_ff.operation == pob_pkg::OP_READ) && |(hit_vec & level_now);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_valid_ff) begin
         rsp_ff.pin_levels <= pins_in;
         rsp_ff.read_level <= read_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff |=> rsp_strobe)
      else $error("An accepted item produced no result.");

   a_read_level_only_on_read: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff && cmd_ff.operation != pob_pkg::OP_READ |=> !rsp_payload.read_level)
      else $error("Read level is set for an item that is not a read.");

   a_unused_pins_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.pin_levels >> CHANNELS) == '0)
      else $error("Pin level above the channel count is set.");

   a_all_off_result: assert property (@(posedge clock) disable iff (reset)
      cmd_valid_ff && cmd_ff.operation == pob_pkg::OP_ALL_OFF |=>
         rsp_payload.pin_levels == '0)
      else $error("All-off result shows a level that is still high.");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   localparam int CHANNELS = pob_pkg::CHANNELS_DEFAULT;
   localparam int STALL_LIMIT = 500;
   localparam int TARGET_ITEMS = 650;
   localparam pob_pkg::op_type OP_UNUSED = pob_pkg::op_type'(3'd7);

   class pin_level_tracker;
      logic                         level_q [CHANNELS];
      logic [pob_pkg::LENGTH_W-1:0] count_q [CHANNELS];
      logic                         expired_q [CHANNELS];
      pob_pkg::rsp_type             expected_pins [$];
      int                           mismatches;

      function new();
         for (int i = 0; i < CHANNELS; i++) begin
            level_q[i] = 1'b0;
            count_q[i] = '0;
            expired_q[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      function void apply_item(pob_pkg::req_type item);
         pob_pkg::rsp_type outcome;
         int               ch;
         logic             in_range;
         ch = int'(item.channel);
         in_range = (ch < CHANNELS);
         outcome = '0;
         case (item.operation)
            pob_pkg::OP_SET: begin
               if (in_range) begin
                  level_q[ch] = item.level;
                  count_q[ch] = '0;
                  expired_q[ch] = 1'b0;
               end
            end
            pob_pkg::OP_TOGGLE: begin
               if (in_range) begin
                  level_q[ch] = ~level_q[ch];
                  count_q[ch] = '0;
                  expired_q[ch] = 1'b0;
               end
            end
            pob_pkg::OP_PULSE: begin
               if (in_range && item.pulse_length != '0) begin
                  if (count_q[ch] == '0) level_q[ch] = ~level_q[ch];
                  count_q[ch] = item.pulse_length;
                  expired_q[ch] = 1'b0;
               end
            end
            pob_pkg::OP_ALL_OFF: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  level_q[i] = 1'b0;
                  count_q[i] = '0;
                  expired_q[i] = 1'b0;
               end
            end
            pob_pkg::OP_TICK: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (count_q[i] != '0) begin
                     count_q[i] = count_q[i] - 1'b1;
                     if (count_q[i] == '0) expired_q[i] = 1'b1;
                  end
               end
            end
            pob_pkg::OP_REFRESH: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (expired_q[i]) begin
                     expired_q[i] = 1'b0;
                     level_q[i] = ~level_q[i];
                  end
               end
            end
            pob_pkg::OP_READ: begin
               if (in_range) outcome.read_level = level_q[ch];
            end
            default: begin
            end
         endcase
         for (int i = 0; i < CHANNELS; i++) outcome.pin_levels[i] = level_q[i];
         expected_pins.push_back(outcome);
      endfunction

      task report_mismatch(string what, logic [pob_pkg::PIN_W-1:0] got,
                           logic [pob_pkg::PIN_W-1:0] want);
         $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task compare_result(pob_pkg::rsp_type got);
         pob_pkg::rsp_type want;
         if (expected_pins.size() == 0) begin
            report_mismatch("unexpected result", got.pin_levels, '0);
         end else begin
            want = expected_pins.pop_front();
            if (got.pin_levels !== want.pin_levels)
               report_mismatch("pin_levels", got.pin_levels, want.pin_levels);
            if (got.read_level !== want.read_level)
               report_mismatch("read_level", pob_pkg::PIN_W'(got.read_level),
                               pob_pkg::PIN_W'(want.read_level));
         end
      endtask
   endclass

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pob_pkg::req_type req_payload;
   logic             rsp_strobe;
   pob_pkg::rsp_type rsp_payload;

   pin_level_tracker tracker = new();
   int items_sent;
   int stalled_cycles;
   bit gaps_enabled;

   pulse_output_bank #(.CHANNELS(CHANNELS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.compare_result(rsp_payload);
         if (start && !busy) tracker.apply_item(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   function automatic pob_pkg::req_type make_item(pob_pkg::op_type op, int ch, logic lvl,
                                                  int len);
      pob_pkg::req_type item;
      item.operation = op;
      item.channel = pob_pkg::CHANNEL_W'(ch);
      item.level = lvl;
      item.pulse_length = pob_pkg::LENGTH_W'(len);
      return item;
   endfunction

   task automatic send_item(pob_pkg::req_type item);
      @(negedge clock);
      while (gaps_enabled && $urandom_range(99) < 15) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.expected_pins.size() != 0) @(posedge clock);
   endtask

   function automatic pob_pkg::req_type random_item();
      pob_pkg::req_type item;
      int unsigned      pick;
      pob_pkg::op_type  op;
      pick = $urandom_range(99);
      if (pick < 10) item.pulse_length = '0;
      else if (pick < 75) item.pulse_length = pob_pkg::LENGTH_W'($urandom_range(6, 1));
      else item.pulse_length = pob_pkg::LENGTH_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 12) op = pob_pkg::OP_SET;
      else if (pick < 22) op = pob_pkg::OP_TOGGLE;
      else if (pick < 44) op = pob_pkg::OP_PULSE;
      else if (pick < 72) op = pob_pkg::OP_TICK;
      else if (pick < 84) op = pob_pkg::OP_REFRESH;
      else if (pick < 96) op = pob_pkg::OP_READ;
      else if (pick < 98) op = pob_pkg::OP_ALL_OFF;
      else op = OP_UNUSED;
      item.operation = op;
      item.channel = pob_pkg::CHANNEL_W'($urandom_range(31));
      item.level = 1'($urandom_range(1));
      return item;
   endfunction

   task automatic pulse_train();
      int ch;
      int len;
      ch = $urandom_range(31);
      len = $urandom_range(5, 1);
      send_item(make_item(pob_pkg::OP_PULSE, ch, 1'b0, len));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(3) == 0) send_item(make_item(pob_pkg::OP_READ, ch, 1'b0, 0));
         if ($urandom_range(5) == 0) send_item(random_item());
         send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      end
      send_item(make_item(pob_pkg::OP_REFRESH, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_READ, ch, 1'b0, 0));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      items_sent = 0;
      stalled_cycles = 0;
      gaps_enabled = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of the channel and length fields, every operation, a zero-length
      // pulse, an extended pulse, the unused operation code and expiry handling.
      send_item(make_item(pob_pkg::OP_SET, 0, 1'b1, 0));
      send_item(make_item(pob_pkg::OP_SET, 31, 1'b1, 16'hFFFF));
      send_item(make_item(pob_pkg::OP_TOGGLE, 31, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_READ, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_READ, 31, 1'b1, 16'hFFFF));
      send_item(make_item(pob_pkg::OP_PULSE, 5, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_PULSE, 5, 1'b0, 2));
      send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_PULSE, 5, 1'b1, 3));
      send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_REFRESH, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_REFRESH, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_READ, 5, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_PULSE, 31, 1'b0, 16'hFFFF));
      send_item(make_item(pob_pkg::OP_TICK, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_TOGGLE, 31, 1'b0, 0));
      send_item(make_item(OP_UNUSED, 31, 1'b1, 16'hFFFF));
      send_item(make_item(pob_pkg::OP_ALL_OFF, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_READ, 0, 1'b0, 0));
      send_item(make_item(pob_pkg::OP_SET, 31, 1'b0, 0));
      drain_results();

      while (items_sent < TARGET_ITEMS) begin
         gaps_enabled = !(items_sent > 250 && items_sent < 400);
         if (items_sent > 450 && items_sent < 460) drain_results();
         if ($urandom_range(2) == 0) pulse_train();
         else send_item(random_item());
      end
      drain_results();
      repeat (4) @(posedge clock);

      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
